// File: hw/rtl/lds_pkg.sv
// ----------------------------------------------------------------------------
// lds_pkg
// Shared constants and the token control type for the decreasing-subsequence
// cell row.
// ----------------------------------------------------------------------------
package lds_pkg;

    localparam int MAX_ELEMENTS_DEF = 32;
    localparam int VALUE_W          = 32;
    localparam int OUT_LEN_W        = 6;

    // Control part of the token that walks the cell row
    typedef struct packed {
        logic valid;  // token present in this stage
        logic fin;    // item already stored, just forward
        logic last;   // item closes the sequence
    } lds_tok_t;

endpackage

// File: hw/rtl/lds_cell.sv
// ----------------------------------------------------------------------------
// lds_cell
// One cell of the row: holds one stored element and its subsequence length,
// and passes the travelling token to the next cell every cycle.
// ----------------------------------------------------------------------------
module lds_cell
    import lds_pkg::*;
#(
    parameter int LW = 6,
    parameter int IW = 5
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  lds_tok_t                  tok_in,
    input  logic signed [VALUE_W-1:0] val_in,
    input  logic        [LW-1:0]      max_in,
    input  logic        [IW-1:0]      rem_in,
    output lds_tok_t                  tok_out,
    output logic signed [VALUE_W-1:0] val_out,
    output logic        [LW-1:0]      max_out,
    output logic        [IW-1:0]      rem_out
);

    logic signed [VALUE_W-1:0] stored_val_reg;
    logic        [LW-1:0]      stored_len_reg;

    lds_tok_t                  tok_reg;
    lds_tok_t                  tok_next;
    logic signed [VALUE_W-1:0] val_reg;
    logic        [LW-1:0]      max_reg;
    logic        [LW-1:0]      max_next;
    logic        [IW-1:0]      rem_reg;
    logic        [IW-1:0]      rem_next;
    logic                      hit;
    logic                      scan;

    always_comb
    begin
        hit      = tok_in.valid && !tok_in.fin && (rem_in == '0);
        scan     = tok_in.valid && !tok_in.fin && (rem_in != '0);
        tok_next = tok_in;
        tok_next.fin = tok_in.fin | hit;
        max_next = max_in;
        rem_next = rem_in;
        if (hit)
        begin
            max_next = max_in + 1'b1;
        end
        else if (scan)
        begin
            // occupied cell: take its length if it extends a decreasing run
            if ((stored_val_reg > val_in) && (stored_len_reg > max_in))
            begin
                max_next = stored_len_reg;
            end
            rem_next = rem_in - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_in;
        max_reg <= max_next;
        rem_reg <= rem_next;
        if (hit)
        begin
            stored_val_reg <= val_in;
            stored_len_reg <= max_next;
        end
    end

    assign tok_out = tok_reg;
    assign val_out = val_reg;
    assign max_out = max_reg;
    assign rem_out = rem_reg;

endmodule

// File: hw/rtl/longest_decreasing_subsequence.sv
// ----------------------------------------------------------------------------
// longest_decreasing_subsequence
// Streaming longest strictly decreasing subsequence over signed 32-bit items.
// ----------------------------------------------------------------------------
// Each accepted item yields one result: the length of the longest strictly
// decreasing subsequence ending at it and the best length so far in the
// sequence. Elements live in a row of MAX_ELEMENTS cells; a stored item enters
// as a token at the first cell and moves one cell per cycle, picking up the
// largest length among occupied cells holding a greater value, and is written
// into the first free cell. The token always runs the full row, so no new item
// is accepted until the token of a stored item has left the row. An item
// arriving with the row full is dropped, reported with overflow set and
// length_here zero, and its result goes straight into the output stage. A
// set last flag closes the sequence once its result is formed. Results sit
// in a two-entry output stage, so a stalled result does not hold up the row.
// Cells carry no reset of their contents: a fill count marks which cells
// belong to the current sequence.
// ----------------------------------------------------------------------------
module longest_decreasing_subsequence
    import lds_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic signed [VALUE_W-1:0]   value,
    input  logic                        last,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic        [OUT_LEN_W-1:0] length_here,
    output logic        [OUT_LEN_W-1:0] best_length,
    output logic                        done_res,
    output logic                        overflow
);

    // Lengths reach MAX_ELEMENTS; cell offsets stay below it
    localparam int LW = $clog2(MAX_ELEMENTS + 1);
    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

    typedef struct packed {
        logic [OUT_LEN_W-1:0] length_here;
        logic [OUT_LEN_W-1:0] best_length;
        logic                 done_res;
        logic                 overflow;
    } lds_res_t;

    // Token chain between cells
    lds_tok_t                  tok   [0:MAX_ELEMENTS];
    logic signed [VALUE_W-1:0] tval  [0:MAX_ELEMENTS];
    logic        [LW-1:0]      tmax  [0:MAX_ELEMENTS];
    logic        [IW-1:0]      trem  [0:MAX_ELEMENTS];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic [LW-1:0] best_reg;
    logic [LW-1:0] best_next;
    logic          busy_reg;
    logic          busy_next;

    lds_res_t      out_reg;
    lds_res_t      out_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    lds_res_t      skid_reg;
    lds_res_t      skid_next;
    logic          skid_valid_reg;
    logic          skid_valid_next;

    logic          in_accept;
    logic          full;
    logic          launch;
    logic          ovf_push;
    logic          exit_tok;
    logic [LW-1:0] exit_best;
    logic          push;
    lds_res_t      push_res;
    logic          pop;
    logic          out_free;

    // Hold new items while a token is in the row or the spare slot is taken
    assign in_stall  = busy_reg || skid_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign full      = (count_reg == CW'(MAX_ELEMENTS));
    assign launch    = in_accept && !full;
    assign ovf_push  = in_accept && full;

    // Feed the first cell; the offset counts occupied cells to pass over
    assign tok[0]  = '{valid: launch, fin: 1'b0, last: last};
    assign tval[0] = value;
    assign tmax[0] = '0;
    assign trem[0] = IW'(count_reg);

    for (genvar gi = 0; gi < MAX_ELEMENTS; gi++)
    begin : g_cell
        lds_cell #(
            .LW (LW),
            .IW (IW)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .tok_in  (tok[gi]),
            .val_in  (tval[gi]),
            .max_in  (tmax[gi]),
            .rem_in  (trem[gi]),
            .tok_out (tok[gi+1]),
            .val_out (tval[gi+1]),
            .max_out (tmax[gi+1]),
            .rem_out (trem[gi+1])
        );
    end

    // At the end of the row the token carries the length of the stored item
    assign exit_tok  = tok[MAX_ELEMENTS].valid;
    assign exit_best = (tmax[MAX_ELEMENTS] > best_reg) ? tmax[MAX_ELEMENTS] : best_reg;

    always_comb
    begin
        push = exit_tok || ovf_push;
        if (exit_tok)
        begin
            push_res.length_here = OUT_LEN_W'(tmax[MAX_ELEMENTS]);
            push_res.best_length = OUT_LEN_W'(exit_best);
            push_res.done_res    = tok[MAX_ELEMENTS].last;
            push_res.overflow    = 1'b0;
        end
        else
        begin
            push_res.length_here = '0;
            push_res.best_length = OUT_LEN_W'(best_reg);
            push_res.done_res    = last;
            push_res.overflow    = 1'b1;
        end
    end

    // Fill count set at launch, best at exit; a dropped last item clears both
    always_comb
    begin
        count_next = count_reg;
        best_next  = best_reg;
        busy_next  = busy_reg;
        if (launch)
        begin
            count_next = last ? '0 : count_reg + 1'b1;
            busy_next  = 1'b1;
        end
        if (ovf_push && last)
        begin
            count_next = '0;
            best_next  = '0;
        end
        if (exit_tok)
        begin
            best_next = tok[MAX_ELEMENTS].last ? '0 : exit_best;
            busy_next = 1'b0;
        end
    end

    // Two-entry output stage: result register plus spare slot
    assign pop      = out_valid_reg && !out_stall;
    assign out_free = !out_valid_reg || pop;

    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = push_res;
                skid_valid_next = push;
            end
            else
            begin
                out_next       = push_res;
                out_valid_next = push;
            end
        end
        else if (push)
        begin
            skid_next       = push_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            best_reg       <= '0;
            busy_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg      <= count_next;
            best_reg       <= best_next;
            busy_reg       <= busy_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid   = out_valid_reg;
    assign length_here = out_reg.length_here;
    assign best_length = out_reg.best_length;
    assign done_res    = out_reg.done_res;
    assign overflow    = out_reg.overflow;

endmodule

// File: hw/rtl/lds_checker.sv
// ----------------------------------------------------------------------------
// lds_assertions
// Port-level checks on the result stream of the subsequence block.
// ----------------------------------------------------------------------------
module lds_assertions
    import lds_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 out_valid,
    input logic                 out_stall,
    input logic [OUT_LEN_W-1:0] length_here,
    input logic [OUT_LEN_W-1:0] best_length,
    input logic                 done_res,
    input logic                 overflow
);

    // Lengths only survive the output width when they cannot wrap
    localparam bit NO_WRAP = (MAX_ELEMENTS < (1 << OUT_LEN_W));

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(length_here)
            && $stable(best_length) && $stable(done_res) && $stable(overflow))
        else $error("stalled result changed");

    a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && overflow |-> length_here == '0)
        else $error("dropped item reports a length");

    a_stored_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overflow && NO_WRAP |-> length_here != '0
            && length_here <= OUT_LEN_W'(MAX_ELEMENTS))
        else $error("stored item length out of range");

    a_best_cover: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !overflow && NO_WRAP |-> best_length >= length_here)
        else $error("best length below item length");

endmodule

bind longest_decreasing_subsequence lds_assertions #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
) u_lds_assertions (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .length_here (length_here),
    .best_length (best_length),
    .done_res    (done_res),
    .overflow    (overflow)
);

// File: dv/lds_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lds_checker
// Watches both channels of the decreasing-subsequence block, works out each
// result from its own copy of the cell row and compares all of its fields.
// ----------------------------------------------------------------------------
module lds_checker
    import lds_pkg::*;
#(
    parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic signed [VALUE_W-1:0]   value,
    input  logic                        last,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic        [OUT_LEN_W-1:0] length_here,
    input  logic        [OUT_LEN_W-1:0] best_length,
    input  logic                        done_res,
    input  logic                        overflow,
    output int                          fail_count,
    output int                          outstanding,
    output int                          results_seen,
    output int                          drops_seen
);

    typedef struct packed {
        logic [OUT_LEN_W-1:0] len_here;
        logic [OUT_LEN_W-1:0] best;
        logic                 closes;
        logic                 dropped;
    } lds_result_t;

    localparam int REPORT_LIMIT = 10;

    // Own copy of the row: only entries below row_fill are ever read
    logic signed [VALUE_W-1:0]   row_value  [MAX_ELEMENTS];
    logic        [OUT_LEN_W-1:0] row_length [MAX_ELEMENTS];
    int                          row_fill;
    logic        [OUT_LEN_W-1:0] seq_best;
    lds_result_t                 lengths_due_q [$];
    int                          n_fail;
    int                          n_results;
    int                          n_drops;

    // Store the item (room permitting) and return the result it must produce
    function automatic lds_result_t predict_length(input logic signed [VALUE_W-1:0] v,
                                                    input logic l);
        lds_result_t          r;
        logic [OUT_LEN_W-1:0] longest;
        r        = '0;
        r.closes = l;
        if (row_fill >= MAX_ELEMENTS)
        begin
            r.dropped = 1'b1;
        end
        else
        begin
            longest = '0;
            for (int j = 0; j < row_fill; j++)
            begin
                if (row_value[j] > v && row_length[j] > longest)
                    longest = row_length[j];
            end
            r.len_here           = longest + 1'b1;
            row_value[row_fill]  = v;
            row_length[row_fill] = r.len_here;
            row_fill++;
            if (r.len_here > seq_best)
                seq_best = r.len_here;
        end
        r.best = seq_best;
        if (l)
        begin
            row_fill = 0;
            seq_best = '0;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lds_result_t got;
        lds_result_t want;
        if (!rst_n)
        begin
            row_fill = 0;
            seq_best = '0;
            lengths_due_q.delete();
            n_fail    = 0;
            n_results = 0;
            n_drops   = 0;
        end
        else
        begin
            // Outputs first: a result leaving now belongs to an earlier item
            if (out_valid && !out_stall)
            begin
                got = {length_here, best_length, done_res, overflow};
                n_results++;
                if (lengths_due_q.size() == 0)
                begin
                    n_fail++;
                    if (n_fail <= REPORT_LIMIT)
                        $display("%0t: unexpected result here=%0d best=%0d done=%0b ovf=%0b",
                                 $realtime, got.len_here, got.best, got.closes, got.dropped);
                end
                else
                begin
                    want = lengths_due_q.pop_front();
                    if (want.dropped)
                        n_drops++;
                    if (got !== want)
                    begin
                        n_fail++;
                        if (n_fail <= REPORT_LIMIT)
                            $display({"%0t: mismatch expected here=%0d best=%0d done=%0b ",
                                      "ovf=%0b, got here=%0d best=%0d done=%0b ovf=%0b"},
                                     $realtime, want.len_here, want.best, want.closes,
                                     want.dropped, got.len_here, got.best, got.closes,
                                     got.dropped);
                    end
                end
            end
            if (in_valid && !in_stall)
                lengths_due_q.push_back(predict_length(value, last));
        end
        fail_count   <= n_fail;
        outstanding  <= lengths_due_q.size();
        results_seen <= n_results;
        drops_seen   <= n_drops;
    end

endmodule

// File: dv/tb_longest_decreasing_subsequence.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_longest_decreasing_subsequence
// Stimulus and verdict for the streaming decreasing-subsequence block.
// ----------------------------------------------------------------------------
// A short directed opening covers the value extremes, equal values and single
// item sequences. Random sequences of several shapes follow: wide values,
// narrow values full of repeats, long falling runs, corner values and single
// bit patterns. Some run past the row capacity so that items are dropped, with
// the closing flag landing on stored and dropped items alike. Both channels
// idle at random; a separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_longest_decreasing_subsequence
    import lds_pkg::*;
();

    localparam int CLK_HALF     = 4;
    localparam int ITEM_GOAL    = 1700;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = MAX_ELEMENTS_DEF + 16;
    localparam int PAUSE_EVERY  = 16;

    typedef enum int
    {
        SEQ_WIDE,
        SEQ_NARROW,
        SEQ_FALLING,
        SEQ_CORNER,
        SEQ_ONE_BIT
    } seq_shape_t;

    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

    logic                        clk       = 1'b0;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic signed [VALUE_W-1:0]   value     = '0;
    logic                        last      = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic        [OUT_LEN_W-1:0] length_here;
    logic        [OUT_LEN_W-1:0] best_length;
    logic                        done_res;
    logic                        overflow;

    int fail_count;
    int outstanding;
    int results_seen;
    int drops_seen;

    // Calm stretches: no new idle starts on either side while this is set
    logic calm        = 1'b1;
    int   items_sent  = 0;
    int   seqs_closed = 0;
    int   cycle_count = 0;
    int   stall_left  = 0;

    longest_decreasing_subsequence #(
        .MAX_ELEMENTS (MAX_ELEMENTS_DEF)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .value       (value),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .length_here (length_here),
        .best_length (best_length),
        .done_res    (done_res),
        .overflow    (overflow)
    );

    lds_checker #(
        .MAX_ELEMENTS (MAX_ELEMENTS_DEF)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .value        (value),
        .last         (last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .length_here  (length_here),
        .best_length  (best_length),
        .done_res     (done_res),
        .overflow     (overflow),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .drops_seen   (drops_seen)
    );

    // 8 ns clock
    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Watchdog: end the run once the cycle limit is reached
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still due", cycle_count,
                     outstanding);
            $display("TB_ERROR");
            $finish;
        end
    end

    // Idle length: mostly none or short, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Receiver: hold off results at random, starting no new hold-off while calm
    always @(negedge clk)
    begin
        if (stall_left == 0 && !calm && $urandom_range(0, 99) < 30)
            stall_left = pick_idle();
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    // Offer one item; enter and leave on a falling edge. Valid stays high when
    // the next item follows without a gap, so it is never dropped and raised
    // in the same step.
    task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic l);
        int gap;
        gap = calm ? 0 : pick_idle();
        if (gap > 0)
        begin
            // Drop valid and scramble the idle payload
            in_valid <= 1'b0;
            value    <= $urandom;
            last     <= $urandom_range(0, 1);
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        value    <= v;
        last     <= l;
        // Hold the payload until the block takes it
        do
            @(posedge clk);
        while (in_stall);
        items_sent++;
        if (l)
            seqs_closed++;
        @(negedge clk);
    endtask

    // Stop offering items until every result has come back
    task automatic drain_results();
        in_valid <= 1'b0;
        wait (outstanding == 0);
        @(negedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] next_value(input seq_shape_t shape,
                                                            input int idx,
                                                            input logic signed [VALUE_W-1:0] prev);
        int t;
        int k;
        case (shape)
            SEQ_NARROW:
            begin
                // Tiny range: plenty of equal values
                t = $urandom_range(0, 12);
                return t - 6;
            end
            SEQ_FALLING:
            begin
                // Long decreasing runs with the odd rise and repeat
                if (idx == 0)
                    return $urandom;
                if ($urandom_range(0, 99) < 15)
                    return prev + $urandom_range(0, 1 << 20);
                return prev - $urandom_range(0, 1 << 20);
            end
            SEQ_CORNER:
            begin
                case ($urandom_range(0, 7))
                    0:       return VAL_MIN;
                    1:       return VAL_MIN + 1;
                    2:       return -1;
                    3:       return 0;
                    4:       return 1;
                    5:       return VAL_MAX - 1;
                    6:       return VAL_MAX;
                    default: return -2;
                endcase
            end
            SEQ_ONE_BIT:
            begin
                k = $urandom_range(0, VALUE_W - 1);
                return $urandom_range(0, 1) ? (32'sd1 <<< k) : ~(32'sd1 <<< k);
            end
            default:
                return $urandom;
        endcase
    endfunction

    // One whole sequence; the closing flag goes on its final item
    task automatic run_sequence(input seq_shape_t shape, input int len);
        logic signed [VALUE_W-1:0] v;
        v = '0;
        for (int i = 0; i < len; i++)
        begin
            v = next_value(shape, i, v);
            send_item(v, i == len - 1);
        end
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(1, 12);
        if (r < 80)
            return $urandom_range(13, MAX_ELEMENTS_DEF - 1);
        if (r < 92)
            // At or past the row capacity: any items beyond it are dropped
            return $urandom_range(MAX_ELEMENTS_DEF, MAX_ELEMENTS_DEF + 8);
        return MAX_ELEMENTS_DEF + $urandom_range(0, 1);
    endfunction

    function automatic seq_shape_t pick_shape();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return SEQ_FALLING;
        if (r < 55)
            return SEQ_WIDE;
        if (r < 75)
            return SEQ_NARROW;
        if (r < 88)
            return SEQ_CORNER;
        return SEQ_ONE_BIT;
    endfunction

    initial
    begin
        int n_random;
        n_random = 0;

        // Hold reset, then release it on a falling edge
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening, no idling: single item sequences at both extremes
        send_item(VAL_MAX, 1'b1);
        send_item(VAL_MIN, 1'b1);
        // Equal values must not extend a run; a rise restarts at a shorter length
        send_item(VAL_MAX, 1'b0);
        send_item(0, 1'b0);
        send_item(0, 1'b0);
        send_item(-1, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(VAL_MIN, 1'b0);
        send_item(7, 1'b0);
        send_item(1, 1'b1);
        // Alternating bit patterns, sign flipping between neighbours
        send_item(32'sh5555_5555, 1'b0);
        send_item(32'shaaaa_aaaa, 1'b0);
        send_item(1, 1'b0);
        send_item(32'shffff_fffe, 1'b1);

        // Let everything come back before the row is pushed to capacity
        drain_results();

        // Fill the row: close on a dropped item, on the last stored item, and
        // on the first dropped item
        calm = 1'b0;
        run_sequence(SEQ_FALLING, MAX_ELEMENTS_DEF + 2);
        run_sequence(SEQ_CORNER, MAX_ELEMENTS_DEF);
        run_sequence(SEQ_NARROW, MAX_ELEMENTS_DEF + 1);

        // Random sequences until the item goal is reached
        while (items_sent < ITEM_GOAL)
        begin
            calm = ($urandom_range(0, 3) == 0);
            run_sequence(pick_shape(), pick_length());
            n_random++;
            if (n_random % PAUSE_EVERY == 0)
                drain_results();
        end
        in_valid <= 1'b0;

        // Wait for the tail, then give stray results a chance to show up
        wait (outstanding == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d items in %0d sequences (%0d random), %0d results compared.",
                 items_sent, seqs_closed, n_random, results_seen);
        $display("%0d items dropped on a full row, %0d failures, %0d results never came.",
                 drops_seen, fail_count, outstanding);
        if (fail_count == 0 && outstanding == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/lds_pkg.sv
hw/rtl/lds_cell.sv
hw/rtl/longest_decreasing_subsequence.sv
hw/rtl/lds_checker.sv
dv/lds_checker.sv
dv/tb_longest_decreasing_subsequence.sv
